/* design/krt_pkg.sv */
package krt_pkg;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int LEVEL_W  = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;

    // Default table size and the cap on records emitted by one list command
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    // Command codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LIST   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [KEY_W-1:0]   key;
        logic signed [LEVEL_W-1:0] level_in;
    } t_command;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [POS_W-1:0]          position;
        logic signed [KEY_W-1:0]   key_out;
        logic signed [LEVEL_W-1:0] level_out;
        logic                      last;
    } t_result;

    // One stored record
    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic signed [LEVEL_W-1:0] level;
    } t_record;

endpackage

/* design/krt_store.sv */
module krt_store #(
    parameter int ADDR_W = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  krt_pkg::t_record i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output krt_pkg::t_record o_rd_data
);
    import krt_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    t_record r_mem [DEPTH];
    t_record r_rd_data;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/keyed_record_table.sv */
// Ordered table of keyed records (signed key, signed level).
//
// Command channel: present i_cmd with start high; the command transfers at a
// rising edge where start is high and busy is low. busy stays high while a
// command is being worked on.
// Result channel: each result sits on o_result for one cycle with
// o_result_strobe high; the receiver takes it then and cannot stall.
// List streams one result per cycle with last set on the final one; every
// other command returns a single result with last set. Actions 5..7 are
// dropped without a result.
//
// Timing: records live in a one-port-read, one-port-write memory with a
// registered read, and the search walks it one entry per cycle.
// Full-table insert, and any command but insert on an empty table: result
// in the cycle after the transfer. Search hit at position p: result once
// the walk reaches p; a miss, a fresh insert among them, walks all count
// records. Delete then moves the later records down. List: first record
// once entry 0 is read, then one per cycle. The next command can transfer
// at the edge that takes the last result, or after the delete shift.
// Reset clears the count and control state, not the memory.
module keyed_record_table #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  krt_pkg::t_command i_cmd,
    output logic              busy,
    output logic              o_result_strobe,
    output krt_pkg::t_result  o_result
);
    import krt_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_LIST  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_command         r_cmd, n_cmd;
    logic             r_out_vld, n_out_vld;
    t_result          r_out, n_out;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_record          wr_data;
    logic [CNT_W-1:0] rd_idx;
    t_record          rd_data;

    logic             accept;
    logic             key_hit;
    logic             at_end;
    logic             list_last;
    logic [CNT_W:0]   idx_plus1;
    logic [CNT_W:0]   idx_plus2;
    logic [CNT_W:0]   count_ext;

    krt_store #(
        .ADDR_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign accept    = start && !busy;
    assign key_hit   = (rd_data.key == r_cmd.key);
    assign at_end    = (r_idx == r_count);
    assign idx_plus1 = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign idx_plus2 = {1'b0, r_idx} + (CNT_W+1)'(2);
    assign count_ext = {1'b0, r_count};
    assign list_last = (idx_plus1 == count_ext) ||
                       ((CAPACITY > MAX_RESULTS) && (idx_plus1 == (CNT_W+1)'(MAX_RESULTS)));

    // Command sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_out_vld = 1'b0;
        n_out     = r_out;
        wr_en     = 1'b0;
        wr_addr   = r_idx[IDX_W-1:0];
        wr_data   = rd_data;
        rd_idx    = r_idx;

        case (r_state)
            S_IDLE: begin
                n_idx  = '0;
                rd_idx = '0;
                if (accept) begin
                    n_cmd = i_cmd;
                    if (i_cmd.action inside {[ACT_INSERT:ACT_DELETE]}) begin
                        if (i_cmd.action == ACT_INSERT &&
                            r_count == CNT_W'(CAPACITY)) begin
                            n_out_vld = 1'b1;
                            n_out     = '{STAT_FULL, '0, '0, '0, 1'b1};
                        end else if (i_cmd.action != ACT_INSERT && r_count == '0) begin
                            n_out_vld = 1'b1;
                            n_out     = '{STAT_EMPTY, '0, '0, '0, 1'b1};
                        end else if (i_cmd.action == ACT_LIST) begin
                            n_state = S_LIST;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            // Compare one stored record per cycle against the command key
            S_SCAN: begin
                if (at_end) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_cmd.action == ACT_INSERT) begin
                        wr_en   = 1'b1;
                        wr_data = '{r_cmd.key, r_cmd.level_in};
                        n_count = r_count + CNT_W'(1);
                        n_out   = '{STAT_OK, POS_W'(r_idx), r_cmd.key,
                                    r_cmd.level_in, 1'b1};
                    end else begin
                        n_out = '{STAT_MISSING, '0, '0, '0, 1'b1};
                    end
                end else if (key_hit) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    n_out     = '{STAT_OK, POS_W'(r_idx), rd_data.key,
                                  rd_data.level, 1'b1};
                    case (r_cmd.action)
                        ACT_INSERT: begin
                            n_out.status = STAT_DUP;
                        end
                        ACT_UPDATE: begin
                            wr_en           = 1'b1;
                            wr_data         = '{rd_data.key, r_cmd.level_in};
                            n_out.level_out = r_cmd.level_in;
                        end
                        ACT_DELETE: begin
                            if (idx_plus1 < count_ext) begin
                                n_state = S_SHIFT;
                                rd_idx  = idx_plus1[CNT_W-1:0];
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    n_idx  = idx_plus1[CNT_W-1:0];
                    rd_idx = idx_plus1[CNT_W-1:0];
                end
            end

            // Stream records in position order
            S_LIST: begin
                n_out_vld = 1'b1;
                n_out     = '{STAT_OK, POS_W'(r_idx), rd_data.key,
                              rd_data.level, list_last};
                n_idx     = idx_plus1[CNT_W-1:0];
                rd_idx    = idx_plus1[CNT_W-1:0];
                if (list_last) begin
                    n_state = S_IDLE;
                end
            end

            // Move record r_idx+1 down into r_idx
            S_SHIFT: begin
                wr_en = 1'b1;
                if (idx_plus2 < count_ext) begin
                    n_idx  = idx_plus1[CNT_W-1:0];
                    rd_idx = idx_plus2[CNT_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_out_vld;
    assign o_result        = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("record count above capacity");

    a_shift_only_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> r_cmd.action == ACT_DELETE)
        else $error("shift pass outside a delete");

    a_list_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result.last |=> o_result_strobe)
        else $error("list stream broke before last");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |-> $past(r_state) != S_IDLE)
        else $error("record count changed while idle");

endmodule

/* verif/keyed_record_table_tb.sv */
module keyed_record_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import krt_pkg::*;

    // Action codes the block drops without a reply
    localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // Cycles to let a delete finish shifting, or a dropped command clear
    localparam int SETTLE_CYCLES = 3 * CAPACITY_DEF;
    localparam int POOL_SIZE     = 24;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    t_command i_cmd   = '0;
    logic     busy;
    logic     o_result_strobe;
    t_result  o_result;

    // Shadow copy of the table contents
    t_record recs [CAPACITY_DEF];
    int      rec_count = 0;

    // Replies predicted but not yet seen, oldest first
    t_result pending_replies [$];
    int      fault_count = 0;

    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    keyed_record_table #(
        .CAPACITY(CAPACITY_DEF)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .busy           (busy),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic string reply_text(t_result r);
        return $sformatf("status %0d pos %0d key %0d level %0d last %0b",
                         r.status, r.position, r.key_out, r.level_out, r.last);
    endfunction

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic void post_reply(logic [STATUS_W-1:0] st, int idx,
                                       logic signed [KEY_W-1:0] k,
                                       logic signed [LEVEL_W-1:0] lv, logic fin);
        t_result r;
        r.status    = st;
        r.position  = POS_W'(idx);
        r.key_out   = k;
        r.level_out = lv;
        r.last      = fin;
        pending_replies.push_back(r);
    endfunction

    // First position holding key k, or rec_count on a miss
    function automatic int find_key(logic signed [KEY_W-1:0] k);
        for (int i = 0; i < rec_count; i++) begin
            if (recs[i].key == k) return i;
        end
        return rec_count;
    endfunction

    function automatic void predict_replies(t_command c);
        int idx;
        int n;
        if (c.action == ACT_INSERT) begin
            if (rec_count >= CAPACITY_DEF) begin
                post_reply(STAT_FULL, 0, '0, '0, 1'b1);
                return;
            end
            idx = find_key(c.key);
            if (idx < rec_count) begin
                post_reply(STAT_DUP, idx, recs[idx].key, recs[idx].level, 1'b1);
                return;
            end
            recs[rec_count].key   = c.key;
            recs[rec_count].level = c.level_in;
            post_reply(STAT_OK, rec_count, c.key, c.level_in, 1'b1);
            rec_count++;
            return;
        end
        if (c.action != ACT_LIST && c.action != ACT_LOOKUP &&
            c.action != ACT_UPDATE && c.action != ACT_DELETE) begin
            return;
        end
        if (rec_count == 0) begin
            post_reply(STAT_EMPTY, 0, '0, '0, 1'b1);
            return;
        end
        if (c.action == ACT_LIST) begin
            n = (rec_count > MAX_RESULTS) ? MAX_RESULTS : rec_count;
            for (int i = 0; i < n; i++) begin
                post_reply(STAT_OK, i, recs[i].key, recs[i].level, i == n - 1);
            end
            return;
        end
        idx = find_key(c.key);
        if (idx >= rec_count) begin
            post_reply(STAT_MISSING, 0, '0, '0, 1'b1);
            return;
        end
        case (c.action)
            ACT_LOOKUP: begin
                post_reply(STAT_OK, idx, recs[idx].key, recs[idx].level, 1'b1);
            end
            ACT_UPDATE: begin
                recs[idx].level = c.level_in;
                post_reply(STAT_OK, idx, recs[idx].key, c.level_in, 1'b1);
            end
            default: begin
                // delete: report the removed record, close the gap
                post_reply(STAT_OK, idx, recs[idx].key, recs[idx].level, 1'b1);
                for (int j = idx; j + 1 < rec_count; j++) begin
                    recs[j] = recs[j + 1];
                end
                rec_count--;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Reply checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_replies
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_replies.size() == 0) begin
                log_fault({"unexpected reply: ", reply_text(o_result)});
            end else begin
                want = pending_replies.pop_front();
                if (o_result.status !== want.status ||
                    o_result.position !== want.position ||
                    o_result.key_out !== want.key_out ||
                    o_result.level_out !== want.level_out ||
                    o_result.last !== want.last) begin
                    log_fault({"reply mismatch\n  expected: ", reply_text(want),
                               "\n  actual:   ", reply_text(o_result)});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    function automatic t_command make_command(logic [ACTION_W-1:0] act,
                                              logic signed [KEY_W-1:0] k,
                                              logic signed [LEVEL_W-1:0] lv);
        t_command c;
        c.action   = act;
        c.key      = k;
        c.level_in = lv;
        return c;
    endfunction

    // Present one command, wait for its transfer, then maybe go idle.
    // With no idle gap start stays high, so the next call must follow in
    // the same time step (or drain_replies must).
    task automatic send_command(input t_command c, input int idle_pct);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_replies(c);
        // each idle cycle is drawn on its own
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted reply is back and the block is quiet
    task automatic drain_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        send_command(make_command(ACT_LIST, '0, '0), 0);
        send_command(make_command(ACT_LOOKUP, '0, '0), 0);
        send_command(make_command(ACT_UPDATE, KEY_MAX, KEY_MIN), 0);
        send_command(make_command(ACT_DELETE, KEY_MIN, KEY_MAX), 0);
        // unused action with every field bit set: dropped
        send_command(make_command(ACT_UNUSED_LAST, '1, '1), 0);
        drain_replies();
    endtask

    task automatic test_fill_to_capacity();
        logic signed [KEY_W-1:0] k;
        for (int i = 0; i < CAPACITY_DEF; i++) begin
            case (i)
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                3:       k = '1;
                default: k = (i * 32'h1111_1111) ^ 32'hA5A5_0000;
            endcase
            send_command(make_command(ACT_INSERT, k, ~k), 0);
        end
        // duplicates of the last and the first record
        send_command(make_command(ACT_INSERT, recs[CAPACITY_DEF-1].key, '0), 0);
        send_command(make_command(ACT_INSERT, KEY_MIN, '0), 0);
        // fresh key on a full table
        send_command(make_command(ACT_INSERT, 32'sd12345, 32'sd1), 0);
        send_command(make_command(ACT_LIST, '0, '0), 0);
        drain_replies();
    endtask

    task automatic test_search_and_edit();
        send_command(make_command(ACT_LOOKUP, KEY_MAX, '0), 0);
        send_command(make_command(ACT_LOOKUP, 32'sd12345, '0), 0);
        send_command(make_command(ACT_UPDATE, '1, KEY_MIN), 0);
        send_command(make_command(ACT_UPDATE, 32'sd12345, KEY_MAX), 0);
        // delete at the head shifts every later record
        send_command(make_command(ACT_DELETE, KEY_MIN, '0), 0);
        send_command(make_command(ACT_DELETE, recs[rec_count-1].key, '0), 0);
        send_command(make_command(ACT_LIST, '0, '0), 0);
        drain_replies();
    endtask

    // Mostly well-formed traffic on a small key pool so hits, duplicates,
    // a full table and an emptied table all come up. Epochs alternate
    // between insert-heavy and delete-heavy.
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        t_command c;
        int       r;
        bit       filling;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        for (int i = 0; i < n_items; i++) begin
            filling = ((i / 40) % 2) == 0;
            r = $urandom_range(99);
            if (r < 3) begin
                c.action = ACT_UNUSED_FIRST + ACTION_W'($urandom_range(2));
            end else if (filling) begin
                if (r < 45)      c.action = ACT_INSERT;
                else if (r < 55) c.action = ACT_LIST;
                else if (r < 75) c.action = ACT_LOOKUP;
                else if (r < 90) c.action = ACT_UPDATE;
                else             c.action = ACT_DELETE;
            end else begin
                if (r < 20)      c.action = ACT_INSERT;
                else if (r < 27) c.action = ACT_LIST;
                else if (r < 50) c.action = ACT_LOOKUP;
                else if (r < 65) c.action = ACT_UPDATE;
                else             c.action = ACT_DELETE;
            end
            if (rec_count > 0 && $urandom_range(1) == 0) begin
                c.key = recs[$urandom_range(rec_count - 1)].key;
            end else if ($urandom_range(9) < 8) begin
                c.key = key_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                c.key = $urandom;
            end
            c.level_in = $urandom;
            send_command(c, idle_pct);
        end
        drain_replies();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_fill_to_capacity();
        test_search_and_edit();
        test_random_traffic(0, 170);
        test_random_traffic(71, 170);
        test_random_traffic(14, 170);

        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
